[rtl/hacd_pkg.sv]
// Package for the Alt-code keyboard report decoder.
// Holds the report, command and result types, the report classes and the sizing constants.
// No dependencies.
package hacd_pkg;

    // Default limits for the top level parameters, and the queue depth
    localparam int MAX_OUTPUT_CHARS_DEF = 64;
    localparam int MAX_REPORTS_DEF      = 1024;
    localparam int QUEUE_DEPTH          = 2;

    // Report byte values
    localparam logic [7:0] MOD_LEFT_ALT = 8'h04;
    localparam logic [7:0] KEY_TAG      = 8'h53;
    localparam logic [7:0] KEY_PAD_ZERO = 8'h62;
    localparam logic [7:0] KEY_PAD_ONE  = 8'h59;
    localparam logic [7:0] KEY_PAD_NINE = 8'h61;

    // Keypad digit code for a key that is not a keypad digit
    localparam logic [3:0] DIGIT_NONE = 4'hF;

    // Buffer sizes and saturation limits
    localparam int HELD_DEPTH = 3;
    localparam int HELD_SAT   = 4;
    localparam int TAG_SAT    = 2;

    // Report classes
    typedef enum logic [1:0] {
        CLS_OTHER,
        CLS_SEP,
        CLS_TAG,
        CLS_KEY
    } cls_t;

    // One keyboard report as it arrives
    typedef struct packed {
        logic       start_scan;
        logic       final_report;
        logic [7:0] modifier;
        logic [7:0] reserved_byte;
        logic [7:0] key_0;
        logic [7:0] key_1;
        logic [7:0] key_2;
        logic [7:0] key_3;
        logic [7:0] key_4;
        logic [7:0] key_5;
    } report_t;

    // Classified report, passed from the front to the back
    typedef struct packed {
        logic       start_scan;
        logic       final_report;
        cls_t       cls;
        logic [3:0] digit;
        logic       unclean;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic       char_valid;
        logic [6:0] character;
        logic       scan_end;
        logic       scan_ok;
    } result_t;

endpackage

[rtl/hid_alt_code_report_decoder.sv]
// Alt-code keyboard report decoder, top level.
// Flow: a report is classified on its way into the command queue; the back stage pops it and
// writes its result into the result queue at the same edge, from where it can be transferred out.
// Throughput: one report per cycle while the result queue has room;
// both queues are two entries deep.
// Reset (rst_n, asynchronous, active low) empties both queues and clears scan state but held digits.
// Depends on hacd_pkg, hacd_front, hacd_fifo and hacd_back.
module hid_alt_code_report_decoder #(
    parameter int MAX_OUTPUT_CHARS = hacd_pkg::MAX_OUTPUT_CHARS_DEF,
    parameter int MAX_REPORTS      = hacd_pkg::MAX_REPORTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  hacd_pkg::report_t report,
    output logic              empty,
    input  logic              pop,
    output hacd_pkg::result_t result
);

    import hacd_pkg::*;

    cmd_t    front_cmd;
    cmd_t    back_cmd;
    logic    cmd_empty;
    logic    cmd_pop;
    result_t back_res;
    logic    res_full;
    logic    res_push;

    // Classify incoming reports
    hacd_front u_front (
        .report (report),
        .cmd    (front_cmd)
    );

    // Queue classified reports for the back stage
    hacd_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_cmd),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (back_cmd),
        .empty (cmd_empty)
    );

    // Run scan state and character match
    hacd_back #(
        .MAX_OUTPUT_CHARS (MAX_OUTPUT_CHARS),
        .MAX_REPORTS      (MAX_REPORTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (back_res),
        .res_full  (res_full),
        .res_push  (res_push)
    );

    // Hold results until transferred out
    hacd_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

[rtl/hacd_fifo.sv]
// Small register queue with push/pop handshakes.
// Generic in width and depth; used between the decoder stages and on the result side.
// No package dependencies.
module hacd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/hacd_front.sv]
// Front stage of the Alt-code decoder: sorts a raw report into its class.
// Depends on hacd_pkg for the report and command types.
module hacd_front (
    input  hacd_pkg::report_t report,
    output hacd_pkg::cmd_t    cmd
);

    import hacd_pkg::*;

    logic rest_zero;
    logic key_zero;

    // Map a key usage code to its keypad digit
    function automatic logic [3:0] pad_digit(input logic [7:0] k);
        logic [7:0] d;
        begin
            d = k - 8'h58;
            if (k == KEY_PAD_ZERO)
            begin
                pad_digit = 4'd0;
            end
            else if (k >= KEY_PAD_ONE && k <= KEY_PAD_NINE)
            begin
                pad_digit = d[3:0];
            end
            else
            begin
                pad_digit = DIGIT_NONE;
            end
        end
    endfunction

    assign rest_zero = (report.reserved_byte | report.key_1 | report.key_2 |
                        report.key_3 | report.key_4 | report.key_5) == 8'h00;
    assign key_zero  = (report.key_0 == 8'h00);

    // Classify the report
    always_comb
    begin
        cmd.start_scan   = report.start_scan;
        cmd.final_report = report.final_report;
        cmd.digit        = pad_digit(report.key_0);
        cmd.unclean      = !rest_zero;
        cmd.cls          = CLS_OTHER;
        if (report.modifier == 8'h00 && key_zero && rest_zero)
        begin
            cmd.cls = CLS_SEP;
        end
        else if (report.modifier == 8'h00 && report.key_0 == KEY_TAG && rest_zero)
        begin
            cmd.cls = CLS_TAG;
        end
        else if (report.modifier == MOD_LEFT_ALT && !(key_zero && rest_zero))
        begin
            cmd.cls = CLS_KEY;
        end
    end

endmodule

[rtl/hacd_back.sv]
// Back stage of the Alt-code decoder: scan state, held digits and the character match.
// Depends on hacd_pkg for the command and result types.
module hacd_back #(
    parameter int MAX_OUTPUT_CHARS = hacd_pkg::MAX_OUTPUT_CHARS_DEF,
    parameter int MAX_REPORTS      = hacd_pkg::MAX_REPORTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hacd_pkg::cmd_t    cmd,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    output hacd_pkg::result_t res,
    input  logic              res_full,
    output logic              res_push
);

    import hacd_pkg::*;

    localparam int RC_W = $clog2(MAX_REPORTS + 1);
    localparam int EC_W = $clog2(MAX_OUTPUT_CHARS + 1);

    logic            pending_map_reg;
    logic            pending_map_next;
    logic [1:0]      stop_count_reg;
    logic [1:0]      stop_count_next;
    logic [2:0]      held_count_reg;
    logic [2:0]      held_count_next;
    logic [3:0]      held_key_reg [HELD_DEPTH];
    logic [3:0]      held_key_next [HELD_DEPTH];
    logic            held_unclean_reg;
    logic            held_unclean_next;
    logic [EC_W-1:0] emitted_count_reg;
    logic [EC_W-1:0] emitted_count_next;
    logic [RC_W-1:0] report_count_reg;
    logic [RC_W-1:0] report_count_next;
    logic [6:0]      match_char;

    // Character for three held digits, or zero when the code is not in the table
    function automatic logic [6:0] code_lookup(input logic [3:0] d0, input logic [3:0] d1,
                                               input logic [3:0] d2);
        logic [9:0] v;
        logic       hit;
        begin
            v   = 10'(d0) * 10'd100 + 10'(d1) * 10'd10 + 10'(d2);
            hit = (v == 10'd33) || (v >= 10'd45 && v <= 10'd60) ||
                  (v >= 10'd65 && v <= 10'd90) || (v >= 10'd97 && v <= 10'd122);
            if (d0 == DIGIT_NONE || d1 == DIGIT_NONE || d2 == DIGIT_NONE || !hit)
            begin
                code_lookup = 7'd0;
            end
            else
            begin
                code_lookup = v[6:0];
            end
        end
    endfunction

    assign cmd_pop  = !cmd_empty && !res_full;
    assign res_push = cmd_pop;

    // Apply one classified report to the scan state
    always_comb
    begin
        pending_map_next   = pending_map_reg;
        stop_count_next    = stop_count_reg;
        held_count_next    = held_count_reg;
        held_unclean_next  = held_unclean_reg;
        emitted_count_next = emitted_count_reg;
        report_count_next  = report_count_reg;
        held_key_next      = held_key_reg;
        match_char         = code_lookup(held_key_reg[0], held_key_reg[1], held_key_reg[2]);
        res.char_valid     = 1'b0;
        res.character      = 7'd0;

        // drop the scan state, but the held digit values, on the first report of a scan
        if (cmd.start_scan)
        begin
            pending_map_next   = 1'b0;
            stop_count_next    = '0;
            held_count_next    = '0;
            held_unclean_next  = 1'b0;
            emitted_count_next = '0;
            report_count_next  = '0;
        end

        if (report_count_next < RC_W'(MAX_REPORTS) && stop_count_next < 2'(TAG_SAT))
        begin
            report_count_next = report_count_next + 1'b1;

            // map held digits on the report after a separator
            if (pending_map_next)
            begin
                if (held_count_next == 3'(HELD_DEPTH) && !held_unclean_next &&
                    match_char != 7'd0 && emitted_count_next < EC_W'(MAX_OUTPUT_CHARS))
                begin
                    res.char_valid     = 1'b1;
                    res.character      = match_char;
                    emitted_count_next = emitted_count_next + 1'b1;
                end
                pending_map_next  = 1'b0;
                held_count_next   = '0;
                held_unclean_next = 1'b0;
            end

            case (cmd.cls)
                CLS_SEP:
                begin
                    pending_map_next = 1'b1;
                end
                CLS_TAG:
                begin
                    stop_count_next = stop_count_next + 1'b1;
                end
                CLS_KEY:
                begin
                    if (held_count_next < 3'(HELD_DEPTH))
                    begin
                        held_key_next[held_count_next[1:0]] = cmd.digit;
                        if (cmd.unclean)
                        begin
                            held_unclean_next = 1'b1;
                        end
                    end
                    if (held_count_next < 3'(HELD_SAT))
                    begin
                        held_count_next = held_count_next + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.scan_end = cmd.final_report;
        res.scan_ok  = cmd.final_report && (stop_count_next == 2'(TAG_SAT));
    end

    // Hold scan state between transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_map_reg   <= 1'b0;
            stop_count_reg    <= '0;
            held_count_reg    <= '0;
            held_unclean_reg  <= 1'b0;
            emitted_count_reg <= '0;
            report_count_reg  <= '0;
        end
        else if (cmd_pop)
        begin
            pending_map_reg   <= pending_map_next;
            stop_count_reg    <= stop_count_next;
            held_count_reg    <= held_count_next;
            held_unclean_reg  <= held_unclean_next;
            emitted_count_reg <= emitted_count_next;
            report_count_reg  <= report_count_next;
        end
    end

    // Held digits carry no reset
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            held_key_reg <= held_key_next;
        end
    end

`ifndef SYNTHESIS
    a_emit_limit: assert property (@(posedge clk) disable iff (!rst_n)
        emitted_count_reg <= EC_W'(MAX_OUTPUT_CHARS))
        else $error("emitted count beyond limit");

    a_held_limit: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= 3'(HELD_SAT) && stop_count_reg <= 2'(TAG_SAT))
        else $error("held or tag count beyond saturation");

    a_frozen_after_tags: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && !cmd.start_scan && stop_count_reg == 2'(TAG_SAT)
        |=> $stable(emitted_count_reg) && $stable(report_count_reg))
        else $error("state moved after closing tag");

    a_char_needs_map: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res.char_valid |-> pending_map_reg && !cmd.start_scan)
        else $error("character emitted without pending map");
`endif

endmodule
